### design/lts_pkg.sv
// ----------------------------------------------------------------------------
// lts_pkg
// Shared types, token codes, keyword tables and character classes for the
// lexical token scanner.
// ----------------------------------------------------------------------------
package lts_pkg;

   localparam int NUM_KW     = 8;
   localparam int KW_MAXLEN  = 7;
   localparam int FIFO_DEPTH = 4;
   localparam int PTR_W      = 2;
   localparam int CNT_W      = 3;

   localparam logic [1:0] KIND_OPER    = 2'd0;
   localparam logic [1:0] KIND_KEYWORD = 2'd1;
   localparam logic [1:0] KIND_IDENT   = 2'd2;
   localparam logic [1:0] KIND_NUMBER  = 2'd3;

   localparam logic [7:0] CHAR_NUL = 8'h00;

   // int float if else while for return include
   localparam logic [7:0] KW_TEXT [0:NUM_KW-1][0:KW_MAXLEN-1] = '{
      '{"i", "n", "t", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"f", "l", "o", "a", "t", CHAR_NUL, CHAR_NUL},
      '{"i", "f", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"e", "l", "s", "e", CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"w", "h", "i", "l", "e", CHAR_NUL, CHAR_NUL},
      '{"f", "o", "r", CHAR_NUL, CHAR_NUL, CHAR_NUL, CHAR_NUL},
      '{"r", "e", "t", "u", "r", "n", CHAR_NUL},
      '{"i", "n", "c", "l", "u", "d", "e"}
   };

   localparam logic [2:0] KW_LEN [0:NUM_KW-1] = '{
      3'd3, 3'd5, 3'd2, 3'd4, 3'd5, 3'd3, 3'd6, 3'd7
   };

   typedef struct packed {
      logic [1:0]  token_kind;
      logic [31:0] start_position;
      logic [7:0]  token_length;
      logic        length_saturated;
      logic [2:0]  keyword_index;
      logic [7:0]  operator_char;
      logic        last_of_run;
   } result_type;

   function automatic logic is_letter(input logic [7:0] c);
      return (c inside {["a":"z"], ["A":"Z"]});
   endfunction

   function automatic logic is_digit(input logic [7:0] c);
      return (c inside {["0":"9"]});
   endfunction

   function automatic logic is_space(input logic [7:0] c);
      return (c inside {" ", 8'h09, 8'h0A});
   endfunction

   function automatic logic is_oper(input logic [7:0] c);
      return (c inside {"+", "-", "*", "/", "=", "<", ">"});
   endfunction

   // keyword k still matches with character c at position pos
   function automatic logic kw_char_ok(input logic [2:0] k, input logic [2:0] pos,
                                       input logic [7:0] c);
      return (pos < KW_LEN[k]) && (KW_TEXT[k][pos] == c);
   endfunction

endpackage

### design/lts_scan_core.sv
// ----------------------------------------------------------------------------
// lts_scan_core
// Scanner state and per-byte classification; produces up to two results for
// each request it is fired with.
// ----------------------------------------------------------------------------
module lts_scan_core
   import lts_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  logic       clock,
   input  logic       reset,
   input  logic       fire,
   input  logic [7:0] data_byte,
   input  logic       end_of_stream,
   output result_type res_a,
   output result_type res_b,
   output logic [1:0] res_count
);

   localparam int LEN_W = $clog2(MAX_TOKEN_LENGTH + 1);
   localparam int WID_W = LEN_W + 8;

   localparam logic [1:0] MODE_IDLE = 2'd0;
   localparam logic [1:0] MODE_WORD = 2'd1;
   localparam logic [1:0] MODE_NUM  = 2'd2;

   logic [1:0]       mode_ff, mode_in;
   logic [LEN_W-1:0] len_ff, len_in;
   logic             ovf_ff, ovf_in;
   logic [7:0]       mask_ff, mask_in;
   logic [31:0]      start_ff, start_in;
   logic [31:0]      pos_ff, pos_in;

   logic [1:0]       mode_eff;
   logic [WID_W-1:0] len_wide;
   logic [7:0]       ext_mask;
   logic [7:0]       first_mask;
   logic             tok_valid;
   logic             op_valid;
   result_type       tok;
   result_type       op;
   logic             word_char;

   always_comb begin
      mode_eff = (mode_ff == MODE_WORD || mode_ff == MODE_NUM) ? mode_ff : MODE_IDLE;
      len_wide = WID_W'(len_ff);
      word_char = is_letter(data_byte) || is_digit(data_byte) || (data_byte == "_");

      for (int k = 0; k < NUM_KW; k++) begin
         ext_mask[k] = mask_ff[k] && (len_wide < WID_W'(KW_MAXLEN + 1)) &&
                       kw_char_ok(3'(k), len_wide[2:0], data_byte);
         first_mask[k] = kw_char_ok(3'(k), 3'd0, data_byte);
      end

      tok = '0;
      tok.token_kind = (mode_eff == MODE_NUM) ? KIND_NUMBER : KIND_IDENT;
      tok.start_position = start_ff;
      tok.token_length = len_wide[7:0];
      tok.length_saturated = ovf_ff;
      if (mode_eff == MODE_WORD && !ovf_ff) begin
         for (int k = NUM_KW - 1; k >= 0; k--) begin
            if (mask_ff[k] && len_wide == WID_W'(KW_LEN[k])) begin
               tok.token_kind = KIND_KEYWORD;
               tok.keyword_index = 3'(k);
            end
         end
      end

      op = '0;
      op.token_kind = KIND_OPER;
      op.start_position = pos_ff;
      op.token_length = 8'd1;
      op.operator_char = data_byte;
      op.last_of_run = 1'b1;

      mode_in = mode_eff;
      len_in = len_ff;
      ovf_in = ovf_ff;
      mask_in = mask_ff;
      start_in = start_ff;
      pos_in = pos_ff;
      tok_valid = 1'b0;
      op_valid = 1'b0;

      if (fire) begin
         if (end_of_stream) begin
            tok_valid = (mode_eff != MODE_IDLE);
            mode_in = MODE_IDLE;
            len_in = '0;
            ovf_in = 1'b0;
            mask_in = 8'hFF;
            pos_in = '0;
         end else if ((mode_eff == MODE_WORD && word_char) ||
                      (mode_eff == MODE_NUM && is_digit(data_byte))) begin
            if (mode_eff == MODE_WORD) begin
               mask_in = ext_mask;
            end
            if (len_ff >= LEN_W'(MAX_TOKEN_LENGTH)) begin
               ovf_in = 1'b1;
            end else begin
               len_in = len_ff + LEN_W'(1);
            end
            pos_in = pos_ff + 32'd1;
         end else begin
            tok_valid = (mode_eff != MODE_IDLE);
            mode_in = MODE_IDLE;
            len_in = '0;
            ovf_in = 1'b0;
            mask_in = 8'hFF;
            if (is_oper(data_byte)) begin
               op_valid = 1'b1;
            end else if (is_letter(data_byte) || is_digit(data_byte)) begin
               mode_in = is_letter(data_byte) ? MODE_WORD : MODE_NUM;
               start_in = pos_ff;
               len_in = LEN_W'(1);
               mask_in = is_letter(data_byte) ? first_mask : 8'hFF;
            end
            pos_in = pos_ff + 32'd1;
         end
      end

      tok.last_of_run = !op_valid;
      res_a = tok_valid ? tok : op;
      res_b = op;
      res_count = {1'b0, tok_valid} + {1'b0, op_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff <= MODE_IDLE;
         len_ff <= '0;
         ovf_ff <= 1'b0;
         mask_ff <= 8'hFF;
         start_ff <= '0;
         pos_ff <= '0;
      end else begin
         mode_ff <= mode_in;
         len_ff <= len_in;
         ovf_ff <= ovf_in;
         mask_ff <= mask_in;
         start_ff <= start_in;
         pos_ff <= pos_in;
      end
   end

endmodule

### design/lts_result_fifo.sv
// ----------------------------------------------------------------------------
// lts_result_fifo
// Four-entry result queue; up to two in per cycle, one out unless rsp_stall.
// ----------------------------------------------------------------------------
module lts_result_fifo
   import lts_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  result_type push_a,
   input  result_type push_b,
   input  logic [1:0] push_count,
   output logic       room,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output result_type rsp_data
);

   result_type       entry_ff [0:FIFO_DEPTH-1];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             pop;
   logic [PTR_W-1:0] wr_ptr_next;

   always_comb begin
      room = (count_ff <= CNT_W'(FIFO_DEPTH - 2));
      rsp_valid = (count_ff != '0);
      rsp_data = entry_ff[rd_ptr_ff];
      pop = rsp_valid && !rsp_stall;
      wr_ptr_next = wr_ptr_ff + PTR_W'(1);
      wr_ptr_in = wr_ptr_ff + PTR_W'(push_count);
      rd_ptr_in = rd_ptr_ff + PTR_W'(pop);
      count_in = count_ff + CNT_W'(push_count) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (push_count != 2'd0) begin
         entry_ff[wr_ptr_ff] <= push_a;
      end
      if (push_count == 2'd2) begin
         entry_ff[wr_ptr_next] <= push_b;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff <= count_in;
      end
   end

endmodule

### design/lexical_token_scanner.sv
// ----------------------------------------------------------------------------
// lexical_token_scanner
// Streaming tokenizer: operators, keywords, identifiers and numbers.
//
//   channel  ports                                   direction
//   req      req_valid / req_stall, byte + eos       in, one request per byte
//   rsp      rsp_valid / rsp_stall, token fields     out, 0..2 per request
//
// One request per cycle is taken while req_stall is low; it is held in the
// input register, and its results pass through the four-entry result queue
// to rsp. The input register stalls when fewer than two queue entries are
// free, which only happens after the sink has held results back.
// Synchronous reset clears scanner state, position and the queue.
// ----------------------------------------------------------------------------
module lexical_token_scanner
   import lts_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_data_byte,
   input  logic        req_end_of_stream,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_token_kind,
   output logic [31:0] rsp_start_position,
   output logic [7:0]  rsp_token_length,
   output logic        rsp_length_saturated,
   output logic [2:0]  rsp_keyword_index,
   output logic [7:0]  rsp_operator_char,
   output logic        rsp_last_of_run
);

   logic       in_valid_ff, in_valid_in;
   logic [7:0] in_byte_ff;
   logic       in_eos_ff;
   logic       take;
   logic       fire;
   logic       room;
   result_type res_a;
   result_type res_b;
   logic [1:0] res_count;
   result_type rsp_data;

   assign fire = in_valid_ff && room;
   assign req_stall = in_valid_ff && !room;
   assign take = req_valid && !req_stall;
   assign in_valid_in = take || (in_valid_ff && !fire);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         in_byte_ff <= req_data_byte;
         in_eos_ff <= req_end_of_stream;
      end
   end

   lts_scan_core #(
      .MAX_TOKEN_LENGTH(MAX_TOKEN_LENGTH)
   ) u_core (
      .clock(clock),
      .reset(reset),
      .fire(fire),
      .data_byte(in_byte_ff),
      .end_of_stream(in_eos_ff),
      .res_a(res_a),
      .res_b(res_b),
      .res_count(res_count)
   );

   lts_result_fifo u_fifo (
      .clock(clock),
      .reset(reset),
      .push_a(res_a),
      .push_b(res_b),
      .push_count(res_count),
      .room(room),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   assign rsp_token_kind = rsp_data.token_kind;
   assign rsp_start_position = rsp_data.start_position;
   assign rsp_token_length = rsp_data.token_length;
   assign rsp_length_saturated = rsp_data.length_saturated;
   assign rsp_keyword_index = rsp_data.keyword_index;
   assign rsp_operator_char = rsp_data.operator_char;
   assign rsp_last_of_run = rsp_data.last_of_run;

endmodule
